// ===== rtl/sfct_pkg.sv =====
// Package: widths, opcodes, status and event codes, state types for the filter table.
package sfct_pkg;
    localparam int SLOTS_DEF         = 16;
    localparam int SYSCALL_COUNT_DEF = 512;
    localparam int NS_WIDTH_DEF      = 8;

    typedef enum logic [2:0] {
        OP_INSTALL = 3'd0,
        OP_WRITE   = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_DROP    = 3'd3,
        OP_RAISE   = 3'd4,
        OP_CAPCHK  = 3'd5,
        OP_SYSCHK  = 3'd6,
        OP_UNUSED  = 3'd7
    } op_t;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_INVAL  = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_NOENT  = 3'd3;
    localparam logic [2:0] ST_LOCKED = 3'd4;
    localparam logic [2:0] ST_PERM   = 3'd5;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_BLOCKED = 2'd1;
    localparam logic [1:0] EV_CAPDENY = 2'd2;
    localparam logic [1:0] EV_ALLOWED = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;
endpackage

// ===== rtl/syscall_filter_capability_table.sv =====
// Top level: per-process syscall filter and capability table.
//
//  channel | ports                      | dir | beat
//  --------+----------------------------+-----+------------------------------
//  input   | s_valid/s_ready + fields   | in  | one operation on one pid
//  result  | m_valid/m_ready + fields   | out | status, event, caps, count
//
// Cycles: at the accept edge the pid is matched against all slot registers and
// the bitmap word is read; the next edge applies the update (slot registers and
// bitmap word) and registers the result, offered from the cycle after. With
// m_ready high a new beat is taken in the cycle the previous result leaves.
// Reset: synchronous, active low; slot registers and per-word valid bits
// (SLOTS*WORDS flops) clear at once; install clears the slot's valid bits, so
// no clearing pass is needed.
// Stalls: one item in flight; s_ready stays low while a result waits on m_ready.
module syscall_filter_capability_table
    import sfct_pkg::*;
#(
    parameter int SLOTS         = SLOTS_DEF,
    parameter int SYSCALL_COUNT = SYSCALL_COUNT_DEF,
    parameter int NS_WIDTH      = NS_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic signed [31:0] s_pid,
    input  logic [1:0]         s_mode,
    input  logic               s_lock_request,
    input  logic [7:0]         s_ns_bits,
    input  logic               s_audit_allowed,
    input  logic [63:0]        s_cap_mask,
    input  logic [63:0]        s_cap_drop_extra,
    input  logic [2:0]         s_word_index,
    input  logic [63:0]        s_mask_word,
    input  logic signed [15:0] s_item_number,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [1:0]         m_audit_event,
    output logic [63:0]        m_caps_effective,
    output logic [31:0]        m_violation_count
);
    localparam int WORDS = (SYSCALL_COUNT + 63) / 64;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int DEPTH = SLOTS * (1 << WW);
    localparam int AW    = SW + WW;
    localparam int NSW   = (NS_WIDTH < 8) ? NS_WIDTH : 8;

    // slot registers
    logic [SLOTS-1:0] act_reg;
    logic [30:0]      pid_reg  [SLOTS];
    logic [SLOTS-1:0] bl_reg, lk_reg, aud_reg;
    logic [NSW-1:0]   ns_reg   [SLOTS];
    logic [63:0]      eff_reg  [SLOTS];
    logic [63:0]      perm_reg [SLOTS];
    logic [31:0]      vio_reg  [SLOTS];
    logic [WORDS-1:0] wv_reg   [SLOTS];

    state_t state_reg, state_next;

    // captured item
    op_t         op_reg;
    logic [30:0] ipid_reg;
    logic        ineg_reg;
    logic [1:0]  mode_reg;
    logic        lkq_reg, audq_reg;
    logic [7:0]  nsq_reg;
    logic [63:0] capm_reg, capx_reg, mw_reg;
    logic [2:0]  widx_reg;
    logic signed [15:0] item_reg;

    // lookup results
    logic          hit_reg, free_ok_reg;
    logic [SW-1:0] hs_reg, fs_reg;

    logic [2:0]  st_reg;
    logic [1:0]  ev_reg;
    logic [63:0] oc_reg;
    logic [31:0] ov_reg;

    // lookup on the live beat, registered at the accept edge
    logic          hit_in, free_in;
    logic [SW-1:0] hs_in, fs_in;
    always_comb begin
        hit_in  = 1'b0;
        hs_in   = '0;
        free_in = 1'b0;
        fs_in   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (act_reg[i] && pid_reg[i] == s_pid[30:0] && !s_pid[31]) begin
                hit_in = 1'b1;
                hs_in  = SW'(i);
            end
            if (!act_reg[i]) begin
                free_in = 1'b1;
                fs_in   = SW'(i);
            end
        end
    end

    // bitmap memory: read issued at the accept edge, data used in S_READ
    logic [WW-1:0] rw_in, rw_d;
    logic [AW-1:0] raddr, waddr;
    logic [63:0]   rdata;
    logic          we;
    logic          item_in_range;

    assign rw_in = WW'(s_item_number[15:6]);
    assign rw_d  = WW'(item_reg[15:6]);
    assign item_in_range = (item_reg >= 0) && (32'(item_reg) < SYSCALL_COUNT);
    assign raddr = {hs_in, rw_in};
    assign waddr = {hs_reg, WW'(widx_reg)};
    assign we    = (state_reg == S_READ) && op_reg == OP_WRITE && hit_reg
                   && (32'(widx_reg) < WORDS);

    sfct_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_bitmap (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(mw_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) state_next = S_READ;
            end
            S_READ:  state_next = S_OUT;
            S_OUT: begin
                // next beat may enter as the result leaves
                if (m_ready) begin
                    s_ready    = 1'b1;
                    state_next = s_valid ? S_READ : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid           = (state_reg == S_OUT);
    assign m_status          = st_reg;
    assign m_audit_event     = ev_reg;
    assign m_caps_effective  = oc_reg;
    assign m_violation_count = ov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= op_t'(s_operation);
            ipid_reg <= s_pid[30:0];
            ineg_reg <= s_pid[31];
            mode_reg <= s_mode;
            lkq_reg  <= s_lock_request;
            audq_reg <= s_audit_allowed;
            nsq_reg  <= s_ns_bits;
            capm_reg <= s_cap_mask;
            capx_reg <= s_cap_drop_extra;
            mw_reg   <= s_mask_word;
            widx_reg <= s_word_index;
            item_reg <= s_item_number;
        end
    end

    logic wv_bit;
    logic listed, allow, capbit;

    // a word never written since install reads as zero
    assign wv_bit = wv_reg[hs_reg][rw_d];
    assign listed = item_in_range && wv_bit && rdata[item_reg[5:0]];
    assign allow  = bl_reg[hs_reg] ? !listed : listed;
    assign capbit = eff_reg[hs_reg][item_reg[5:0]];

    // main update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg     <= '0;
            bl_reg      <= '0;
            lk_reg      <= '0;
            aud_reg     <= '0;
            hit_reg     <= 1'b0;
            free_ok_reg <= 1'b0;
            fs_reg      <= '0;
            hs_reg      <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                pid_reg[i]  <= '0;
                ns_reg[i]   <= '0;
                eff_reg[i]  <= '0;
                perm_reg[i] <= '0;
                vio_reg[i]  <= '0;
                wv_reg[i]   <= '0;
            end
        end else if (s_valid && s_ready) begin
            hit_reg     <= hit_in;
            hs_reg      <= hs_in;
            free_ok_reg <= free_in;
            fs_reg      <= fs_in;
        end else if (state_reg == S_READ) begin
            st_reg <= ST_OK;
            ev_reg <= EV_NONE;
            oc_reg <= '0;
            ov_reg <= '0;
            unique case (op_reg)
                OP_INSTALL: begin
                    if (ineg_reg || mode_reg > 2'd1) begin
                        st_reg <= ST_INVAL;
                    end else if (!hit_reg && !free_ok_reg) begin
                        st_reg <= ST_FULL;
                    end else begin
                        act_reg[hit_reg ? hs_reg : fs_reg]  <= 1'b1;
                        pid_reg[hit_reg ? hs_reg : fs_reg]  <= ipid_reg;
                        bl_reg[hit_reg ? hs_reg : fs_reg]   <= mode_reg[0];
                        lk_reg[hit_reg ? hs_reg : fs_reg]   <= lkq_reg;
                        aud_reg[hit_reg ? hs_reg : fs_reg]  <= audq_reg;
                        ns_reg[hit_reg ? hs_reg : fs_reg]   <= nsq_reg[NSW-1:0];
                        eff_reg[hit_reg ? hs_reg : fs_reg]  <= capm_reg & ~capx_reg;
                        perm_reg[hit_reg ? hs_reg : fs_reg] <= capm_reg & ~capx_reg;
                        vio_reg[hit_reg ? hs_reg : fs_reg]  <= '0;
                        wv_reg[hit_reg ? hs_reg : fs_reg]   <= '0;
                        oc_reg <= capm_reg & ~capx_reg;
                    end
                end
                OP_WRITE: begin
                    if (!hit_reg) begin
                        st_reg <= ST_NOENT;
                    end else begin
                        oc_reg <= eff_reg[hs_reg];
                        ov_reg <= vio_reg[hs_reg];
                        if (32'(widx_reg) >= WORDS) st_reg <= ST_INVAL;
                        else wv_reg[hs_reg][WW'(widx_reg)] <= 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (!hit_reg) st_reg <= ST_NOENT;
                    else act_reg[hs_reg] <= 1'b0;
                end
                OP_DROP: begin
                    if (!hit_reg) begin
                        st_reg <= ST_NOENT;
                    end else if (lk_reg[hs_reg]) begin
                        st_reg <= ST_LOCKED;
                        oc_reg <= eff_reg[hs_reg];
                        ov_reg <= vio_reg[hs_reg];
                    end else begin
                        eff_reg[hs_reg]  <= eff_reg[hs_reg] & ~capm_reg;
                        perm_reg[hs_reg] <= perm_reg[hs_reg] & ~capm_reg;
                        oc_reg <= eff_reg[hs_reg] & ~capm_reg;
                        ov_reg <= vio_reg[hs_reg];
                    end
                end
                OP_RAISE: begin
                    if (!hit_reg) begin
                        st_reg <= ST_NOENT;
                    end else begin
                        eff_reg[hs_reg] <= eff_reg[hs_reg] | (capm_reg & perm_reg[hs_reg]);
                        oc_reg <= eff_reg[hs_reg] | (capm_reg & perm_reg[hs_reg]);
                        ov_reg <= vio_reg[hs_reg];
                    end
                end
                OP_CAPCHK: begin
                    if (item_reg < 0 || item_reg > 16'sd63) begin
                        st_reg <= ST_INVAL;
                    end else if (!hit_reg) begin
                        st_reg <= ST_NOENT;
                    end else begin
                        oc_reg <= eff_reg[hs_reg];
                        ov_reg <= vio_reg[hs_reg];
                        if (!capbit) begin
                            st_reg <= ST_PERM;
                            ev_reg <= EV_CAPDENY;
                        end
                    end
                end
                OP_SYSCHK: begin
                    if (hit_reg) begin
                        oc_reg <= eff_reg[hs_reg];
                        ov_reg <= vio_reg[hs_reg];
                        if (!allow) begin
                            st_reg <= ST_PERM;
                            ev_reg <= EV_BLOCKED;
                            vio_reg[hs_reg] <= vio_reg[hs_reg] + 32'd1;
                            ov_reg <= vio_reg[hs_reg] + 32'd1;
                        end else if (aud_reg[hs_reg]) begin
                            ev_reg <= EV_ALLOWED;
                        end
                    end
                end
                default: st_reg <= ST_INVAL;
            endcase
        end
    end

    // assertions
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result pending");
    a_one_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_READ)
        else $error("accepted beat did not start a lookup");
    a_block_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_audit_event == EV_BLOCKED |-> m_status == ST_PERM)
        else $error("blocked syscall without permission status");
endmodule

// ===== rtl/sfct_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module sfct_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== tb/tb_syscall_filter_capability_table.sv =====
// Testbench for the syscall filter and capability table: directed and random beats checked against a model.
`timescale 1ns / 1ps

module tb_syscall_filter_capability_table;
    import sfct_pkg::*;

    localparam int NSLOT = 16;
    localparam int NWORD = 8;
    localparam int SYSCALLS = 512;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1950;

    // one input beat, all fields
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] pid;
        logic [1:0]  mode;
        logic        lock_req;
        logic [7:0]  ns;
        logic        audit;
        logic [63:0] capm;
        logic [63:0] capx;
        logic [2:0]  widx;
        logic [63:0] mword;
        logic [15:0] item;
    } req_t;

    // one result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  event_code;
        logic [63:0] caps;
        logic [31:0] viol;
    } resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_operation = '0;
    logic signed [31:0] s_pid = '0;
    logic [1:0] s_mode = '0;
    logic s_lock_request = 1'b0;
    logic [7:0] s_ns_bits = '0;
    logic s_audit_allowed = 1'b0;
    logic [63:0] s_cap_mask = '0;
    logic [63:0] s_cap_drop_extra = '0;
    logic [2:0] s_word_index = '0;
    logic [63:0] s_mask_word = '0;
    logic signed [15:0] s_item_number = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_status;
    logic [1:0] m_audit_event;
    logic [63:0] m_caps_effective;
    logic [31:0] m_violation_count;

    syscall_filter_capability_table u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_pid(s_pid), .s_mode(s_mode),
        .s_lock_request(s_lock_request), .s_ns_bits(s_ns_bits),
        .s_audit_allowed(s_audit_allowed), .s_cap_mask(s_cap_mask),
        .s_cap_drop_extra(s_cap_drop_extra), .s_word_index(s_word_index),
        .s_mask_word(s_mask_word), .s_item_number(s_item_number),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_audit_event(m_audit_event),
        .m_caps_effective(m_caps_effective),
        .m_violation_count(m_violation_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow of the table, updated in beat acceptance order
    logic        tbl_active   [NSLOT];
    logic [30:0] tbl_pid      [NSLOT];
    logic        tbl_black    [NSLOT];
    logic        tbl_locked   [NSLOT];
    logic        tbl_audit    [NSLOT];
    logic [63:0] tbl_eff      [NSLOT];
    logic [63:0] tbl_perm     [NSLOT];
    logic [31:0] tbl_viol     [NSLOT];
    logic [63:0] tbl_bitmap   [NSLOT][NWORD];

    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    int    errors = 0;
    int    beats_in = 0;
    int    beats_out = 0;
    int    blocked_seen = 0;
    int    full_seen = 0;
    int    idle_cycles = 0;

    // pids used by the random traffic: a small pool so entries get reused
    logic [31:0] pid_pool[24];

    function automatic int lookup_slot(logic [31:0] pid);
        if (pid[31]) return -1;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_active[i] && tbl_pid[i] == pid[30:0]) return i;
        return -1;
    endfunction

    function automatic void wipe_slot(int s);
        tbl_active[s] = 0; tbl_pid[s] = '0; tbl_black[s] = 0;
        tbl_locked[s] = 0; tbl_audit[s] = 0; tbl_eff[s] = '0;
        tbl_perm[s] = '0; tbl_viol[s] = '0;
        for (int w = 0; w < NWORD; w++) tbl_bitmap[s][w] = '0;
    endfunction

    // Computes the result of one beat and applies it to the shadow table
    function automatic resp_t apply_filter_op(req_t r);
        resp_t o;
        int s;
        int it;
        bit listed;
        bit allow;
        o = '0;
        o.status = ST_OK;
        o.event_code = EV_NONE;
        s = -1;
        it = $signed(r.item);
        case (op_t'(r.op))
            OP_INSTALL: begin
                if (r.pid[31] || r.mode > 2'd1) begin
                    o.status = ST_INVAL;
                end else begin
                    s = lookup_slot(r.pid);
                    if (s < 0)
                        for (int i = 0; i < NSLOT; i++)
                            if (!tbl_active[i]) begin
                                s = i;
                                break;
                            end
                    if (s < 0) begin
                        o.status = ST_FULL;
                    end else begin
                        wipe_slot(s);
                        tbl_active[s] = 1;
                        tbl_pid[s] = r.pid[30:0];
                        tbl_black[s] = r.mode[0];
                        tbl_locked[s] = r.lock_req;
                        tbl_audit[s] = r.audit;
                        tbl_eff[s] = r.capm & ~r.capx;
                        tbl_perm[s] = r.capm & ~r.capx;
                    end
                end
            end
            OP_WRITE: begin
                s = lookup_slot(r.pid);
                if (s < 0) o.status = ST_NOENT;
                else tbl_bitmap[s][r.widx] = r.mword;   // all 8 indexes are in range
            end
            OP_REMOVE: begin
                s = lookup_slot(r.pid);
                if (s < 0) o.status = ST_NOENT;
                else begin
                    wipe_slot(s);
                    s = -1;
                end
            end
            OP_DROP: begin
                s = lookup_slot(r.pid);
                if (s < 0) o.status = ST_NOENT;
                else if (tbl_locked[s]) o.status = ST_LOCKED;
                else begin
                    tbl_eff[s] &= ~r.capm;
                    tbl_perm[s] &= ~r.capm;
                end
            end
            OP_RAISE: begin
                s = lookup_slot(r.pid);
                if (s < 0) o.status = ST_NOENT;
                else tbl_eff[s] |= r.capm & tbl_perm[s];
            end
            OP_CAPCHK: begin
                if (it < 0 || it > 63) o.status = ST_INVAL;
                else begin
                    s = lookup_slot(r.pid);
                    if (s < 0) o.status = ST_NOENT;
                    else if (!tbl_eff[s][it]) begin
                        o.status = ST_PERM;
                        o.event_code = EV_CAPDENY;
                    end
                end
            end
            OP_SYSCHK: begin
                s = lookup_slot(r.pid);
                if (s >= 0) begin
                    listed = 0;
                    if (it >= 0 && it < SYSCALLS)
                        listed = tbl_bitmap[s][it >> 6][it & 63];
                    allow = tbl_black[s] ? !listed : listed;
                    if (!allow) begin
                        o.status = ST_PERM;
                        o.event_code = EV_BLOCKED;
                        tbl_viol[s] = tbl_viol[s] + 32'd1;
                    end else if (tbl_audit[s]) begin
                        o.event_code = EV_ALLOWED;
                    end
                end
            end
            default: o.status = ST_INVAL;
        endcase
        if (s >= 0) begin
            o.caps = tbl_eff[s];
            o.viol = tbl_viol[s];
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("MISMATCH beat %0d %s: got %h expected %h", beats_out, what, got, want);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random beat with random content in every field
    function automatic req_t noise_req();
        req_t r;
        logic [319:0] bits;
        bits = {rand64(), rand64(), rand64(), rand64(), rand64()};
        r = bits[257:0];
        r.capm = rand64();
        r.capx = rand64();
        r.mword = rand64();
        return r;
    endfunction

    function automatic logic [63:0] sparse64();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    // Mostly well-formed traffic on pooled pids
    function automatic req_t policy_req();
        req_t r;
        int k;
        r = noise_req();
        r.pid = pid_pool[$urandom_range(0, 23)];
        r.capm = sparse64();
        r.capx = ($urandom_range(0, 2) == 0) ? rand64() : '0;
        r.mword = sparse64();
        k = $urandom_range(0, 99);
        if (k < 14) begin
            r.op = OP_INSTALL;
            r.mode = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                 : 2'($urandom_range(0, 1));
            r.lock_req = ($urandom_range(0, 3) == 0);
        end else if (k < 34) r.op = OP_WRITE;
        else if (k < 40) r.op = OP_REMOVE;
        else if (k < 46) r.op = OP_DROP;
        else if (k < 52) r.op = OP_RAISE;
        else if (k < 62) begin
            r.op = OP_CAPCHK;
            r.item = ($urandom_range(0, 9) == 0) ? r.item : 16'($urandom_range(0, 63));
        end else if (k < 97) begin
            r.op = OP_SYSCHK;
            r.item = ($urandom_range(0, 9) == 0) ? r.item : 16'($urandom_range(0, 511));
        end else r.op = OP_UNUSED;
        return r;
    endfunction

    function automatic req_t mk(op_t op, logic [31:0] pid);
        req_t r;
        r = '0;
        r.op = op;
        r.pid = pid;
        return r;
    endfunction

    // Driver: random gaps, valid held until accepted
    int gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_resps.push_back(apply_filter_op(pending_reqs.pop_front()));
                beats_in++;
            end
            if (!s_valid || s_ready) begin
                if (gap > 0) begin
                    gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    req_t r;
                    r = pending_reqs[0];
                    s_valid <= 1'b1;
                    s_operation <= r.op; s_pid <= r.pid; s_mode <= r.mode;
                    s_lock_request <= r.lock_req; s_ns_bits <= r.ns;
                    s_audit_allowed <= r.audit; s_cap_mask <= r.capm;
                    s_cap_drop_extra <= r.capx; s_word_index <= r.widx;
                    s_mask_word <= r.mword; s_item_number <= r.item;
                    if ($urandom_range(0, 2) == 0)
                        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result beat with the oldest expectation
    int stall = 0;
    int hold_left = 0;   // long receiver hold-off, once early in the run
    bit hold_done = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                resp_t e;
                beats_out++;
                if (expected_resps.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, '0);
                end else begin
                    e = expected_resps.pop_front();
                    if (m_status !== e.status) report_mismatch("status", m_status, e.status);
                    if (m_audit_event !== e.event_code)
                        report_mismatch("audit_event", m_audit_event, e.event_code);
                    if (m_caps_effective !== e.caps)
                        report_mismatch("caps_effective", m_caps_effective, e.caps);
                    if (m_violation_count !== e.viol)
                        report_mismatch("violation_count", m_violation_count, e.viol);
                    if (e.status == ST_FULL) full_seen++;
                    if (e.event_code == EV_BLOCKED) blocked_seen++;
                end
            end
            if (!hold_done && beats_out >= 25) begin
                hold_done = 1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else if (pending_reqs.size() != 0 || expected_resps.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired: %0d in, %0d out", beats_in, beats_out);
            $display("syscall_filter_capability_table regression: fail");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NSLOT; i++) wipe_slot(i);
        for (int i = 0; i < 24; i++) pid_pool[i] = 32'($urandom_range(0, 20));
        pid_pool[0] = 32'h7fff_ffff;
        pid_pool[1] = 32'h0;
        pid_pool[2] = 32'h8000_0000;   // negative pid, never matches
        pid_pool[3] = 32'hffff_ffff;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, each operation, special cases
        begin
            req_t r;
            r = mk(OP_SYSCHK, 32'd5);                 pending_reqs.push_back(r); // no entry
            r = mk(OP_INSTALL, 32'h8000_0000);        pending_reqs.push_back(r); // negative pid
            r = mk(OP_INSTALL, 32'd5); r.mode = 2'd2; pending_reqs.push_back(r); // bad mode
            r = mk(OP_INSTALL, 32'd5); r.mode = 2'd3; pending_reqs.push_back(r);
            r = mk(OP_INSTALL, 32'h7fff_ffff); r.capm = '1; r.capx = 64'hf0;
            r.ns = 8'hff; r.audit = 1; r.lock_req = 1; pending_reqs.push_back(r);
            r = mk(OP_DROP, 32'h7fff_ffff); r.capm = '1; pending_reqs.push_back(r); // locked
            r = mk(OP_WRITE, 32'h7fff_ffff); r.widx = 3'd7; r.mword = '1;
            pending_reqs.push_back(r);
            r = mk(OP_SYSCHK, 32'h7fff_ffff); r.item = 16'd511; pending_reqs.push_back(r);
            r = mk(OP_SYSCHK, 32'h7fff_ffff); r.item = 16'd512; pending_reqs.push_back(r);
            r = mk(OP_SYSCHK, 32'h7fff_ffff); r.item = 16'h8000; pending_reqs.push_back(r);
            r = mk(OP_CAPCHK, 32'h7fff_ffff); r.item = 16'd4; pending_reqs.push_back(r);
            r = mk(OP_CAPCHK, 32'h7fff_ffff); r.item = 16'd63; pending_reqs.push_back(r);
            r = mk(OP_CAPCHK, 32'h7fff_ffff); r.item = 16'd64; pending_reqs.push_back(r);
            r = mk(OP_CAPCHK, 32'd9); r.item = 16'd0; pending_reqs.push_back(r);
            r = mk(OP_INSTALL, 32'd0); r.mode = 2'd1; r.capm = 64'h1; pending_reqs.push_back(r);
            r = mk(OP_DROP, 32'd0); r.capm = 64'h1; pending_reqs.push_back(r);
            r = mk(OP_RAISE, 32'd0); r.capm = '1; pending_reqs.push_back(r);
            r = mk(OP_SYSCHK, 32'd0); r.item = 16'd0; pending_reqs.push_back(r);
            r = mk(OP_WRITE, 32'd3); pending_reqs.push_back(r);  // no entry
            r = mk(OP_REMOVE, 32'd0); pending_reqs.push_back(r);
            r = mk(OP_REMOVE, 32'd0); pending_reqs.push_back(r);
            r = mk(OP_UNUSED, 32'd1); pending_reqs.push_back(r);
            // fill the table, then the last two installs find it full
            for (int i = 0; i < 17; i++) begin
                r = mk(OP_INSTALL, 32'(100 + i)); pending_reqs.push_back(r);
            end
            for (int i = 0; i < 16; i++) begin
                r = mk(OP_REMOVE, 32'(100 + i)); pending_reqs.push_back(r);
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            pending_reqs.push_back(($urandom_range(0, 9) == 0) ? noise_req() : policy_req());
            while (pending_reqs.size() > 8) @(posedge aclk);
        end

        while (pending_reqs.size() != 0 || expected_resps.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d beats in, %0d out: %0d blocked syscalls, %0d table-full installs",
                 beats_in, beats_out, blocked_seen, full_seen);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("syscall_filter_capability_table regression: pass");
        else
            $display("syscall_filter_capability_table regression: fail");
        $finish;
    end
endmodule
